/* rtl/stepper_motor_step_sequencer_unit_macros.svh */
// Assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef STEPPER_MOTOR_STEP_SEQUENCER_UNIT_MACROS_SVH
`define STEPPER_MOTOR_STEP_SEQUENCER_UNIT_MACROS_SVH

// property must hold in every cycle
`define SMSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when cond holds, prop must hold in the next cycle
`define SMSS_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/smss_pkg.sv */
package smss_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DLY_W   = 8;
  localparam int unsigned PROD_W  = PCT_W + POS_W;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned IDX_W   = 2;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**PROD_W
  localparam int unsigned RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [DLY_W-1:0] HOME_DELAY = 8'd8;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_PCT  = 2'd2,
    OP_HOME = 2'd3
  } op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_STEPS_PER_REV = 2'd0,
    REG_DELAY_TICKS   = 2'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_MOVE = 3'b010,
    MODE_HOME = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   pos;
    logic [1:0]         phase;
    logic [CNT_W-1:0]   left;
    logic               down;
    logic [DLY_W-1:0]   tick;
    logic [3:0]         coil;
  } state_t;

  typedef struct packed {
    logic stepped;
    logic rejected;
  } flags_t;

  function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0:    pat = 4'h9;
      2'd1:    pat = 4'hA;
      2'd2:    pat = 4'h6;
      default: pat = 4'h5;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/smss_step.sv */
module smss_step import smss_pkg::*; (
  input  state_t                   st_i,
  input  op_e                      op_i,
  input  logic signed [CNT_W-1:0]  cnt_i,
  input  logic [PROD_W-1:0]        prod_i,
  input  logic [QUO_W-1:0]         quo_i,
  input  logic [POS_W-1:0]         steps_i,
  input  logic [DLY_W-1:0]         delay_i,
  output state_t                   st_o,
  output flags_t                   flags_o
);

  function automatic logic can_step(input logic dn, input logic [POS_W-1:0] p,
                                    input logic [POS_W-1:0] lim);
    return dn ? (p != '0) : (p < lim);
  endfunction

  logic [DLY_W-1:0]  tick_inc;
  logic [DLY_W-1:0]  lim;
  logic [POS_W-1:0]  pos_nx;
  logic [1:0]        ph_nx;
  logic [CNT_W-1:0]  left_dec;
  logic [PROD_W-1:0] quo_x100;
  logic              rem_nz;
  logic              quo_ge;
  logic [CNT_W:0]    pct_cnt;
  logic [CNT_W:0]    mv_cnt;
  logic [CNT_W:0]    mv_mag;
  logic              mv_down;

  always_comb begin
    tick_inc = st_i.tick + 8'd1;
    lim      = (delay_i == '0) ? 8'd1 : delay_i;
    pos_nx   = st_i.down ? st_i.pos - 16'd1 : st_i.pos + 16'd1;
    ph_nx    = st_i.down ? st_i.phase - 2'd1 : st_i.phase + 2'd1;
    left_dec = (st_i.left != '0) ? st_i.left - 17'd1 : st_i.left;

    // signed truncation of (A - 100*pos)/100: floor(A/100) above pos, ceil below
    quo_x100 = PROD_W'(quo_i) * PROD_W'(100);
    rem_nz   = (prod_i != quo_x100);
    quo_ge   = ({1'b0, quo_i} >= {2'b00, st_i.pos});
    pct_cnt  = {1'b0, quo_i} - {2'b00, st_i.pos} + {{CNT_W{1'b0}}, ~quo_ge & rem_nz};

    mv_cnt  = (op_i == OP_PCT) ? pct_cnt : {cnt_i[CNT_W-1], cnt_i};
    mv_down = mv_cnt[CNT_W];
    mv_mag  = mv_down ? (~mv_cnt + 18'd1) : mv_cnt;
  end

  always_comb begin
    st_o    = st_i;
    flags_o = '0;
    if (op_i == OP_TICK) begin
      case (st_i.mode)
        MODE_MOVE: begin
          if (tick_inc < lim) begin
            st_o.tick = tick_inc;
          end else begin
            st_o.tick = '0;
            if (!can_step(st_i.down, st_i.pos, steps_i) || st_i.left == '0) begin
              st_o.mode = MODE_IDLE;
            end else begin
              st_o.pos   = pos_nx;
              st_o.phase = ph_nx;
              st_o.coil  = coil_pattern(ph_nx);
              st_o.left  = left_dec;
              flags_o.stepped = 1'b1;
              if (left_dec == '0 || !can_step(st_i.down, pos_nx, steps_i)) begin
                st_o.mode = MODE_IDLE;
              end
            end
          end
        end
        MODE_HOME: begin
          if (tick_inc < HOME_DELAY) begin
            st_o.tick = tick_inc;
          end else begin
            st_o.tick = '0;
            st_o.left = left_dec;
            if (left_dec != '0) begin
              st_o.coil = coil_pattern(left_dec[1:0]);
              flags_o.stepped = 1'b1;
            end else begin
              st_o.pos  = '0;
              st_o.mode = MODE_IDLE;
            end
          end
        end
        default: ;
      endcase
    end else if (st_i.mode != MODE_IDLE) begin
      flags_o.rejected = 1'b1;
    end else begin
      case (op_i)
        OP_MOVE, OP_PCT: begin
          if (mv_mag != '0) begin
            st_o.down = mv_down;
            if (can_step(mv_down, st_i.pos, steps_i)) begin
              st_o.left = mv_mag[CNT_W-1:0];
              st_o.tick = '0;
              st_o.mode = MODE_MOVE;
            end
          end
        end
        OP_HOME: begin
          if (steps_i == '0) begin
            st_o.pos = '0;
          end else begin
            st_o.left = {1'b0, steps_i};
            st_o.coil = coil_pattern(steps_i[1:0]);
            st_o.tick = '0;
            st_o.mode = MODE_HOME;
            flags_o.stepped = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/stepper_motor_step_sequencer_unit.sv */
// Throughput: one request per cycle unless out_stall_i holds the result; a
// three-register pipeline (input product, divide-by-100 by reciprocal, state
// update into the result register).
// The whole pipeline holds while the result waits under out_stall_i.
// Reset: asynchronous, active low; the state's position, phase, counters and coils clear,
// the block is idle, steps_per_rev reads 0 and delay_ticks reads 1.
`include "stepper_motor_step_sequencer_unit_macros.svh"

module stepper_motor_step_sequencer_unit import smss_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IDX_W-1:0]         cfg_index_i,
  input  logic [POS_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [CNT_W-1:0]  step_count_i,
  input  logic [PCT_W-1:0]         percent_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [3:0]               coils_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     busy_res_o,
  output logic                     stepped_o,
  output logic                     rejected_o
);

  logic [POS_W-1:0] steps_q;
  logic [DLY_W-1:0] delay_q;

  logic adv;
  logic in_acc;

  logic                    v1_q, v2_q, out_valid_q;
  op_e                     op1_q, op2_q;
  logic signed [CNT_W-1:0] cnt1_q, cnt2_q;
  logic [PROD_W-1:0]       prod1_q, prod2_q;
  logic [QUO_W-1:0]        quo2_q;
  logic [PROD_W+RECIP_W-1:0] recip_prod;

  state_t st_q, st_d;
  flags_t flags;

  logic [3:0]       coils_q;
  logic [POS_W-1:0] pos_q;
  logic             busy_q, stepped_q, rejected_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      delay_q <= 8'd1;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_STEPS_PER_REV: steps_q <= cfg_data_i;
        REG_DELAY_TICKS:   delay_q <= cfg_data_i[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // everything moves together unless a finished result is held
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  assign recip_prod = prod1_q * RECIP;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= op_e'(operation_i);
      cnt1_q  <= step_count_i;
      prod1_q <= PROD_W'(percent_i) * PROD_W'(steps_q);
      op2_q   <= op1_q;
      cnt2_q  <= cnt1_q;
      prod2_q <= prod1_q;
      quo2_q  <= recip_prod[RECIP_SHIFT +: QUO_W];
    end
  end

  smss_step u_step (
    .st_i    (st_q),
    .op_i    (op2_q),
    .cnt_i   (cnt2_q),
    .prod_i  (prod2_q),
    .quo_i   (quo2_q),
    .steps_i (steps_q),
    .delay_i (delay_q),
    .st_o    (st_d),
    .flags_o (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_IDLE, default: '0};
    end else if (adv && v2_q) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      coils_q    <= st_d.coil;
      pos_q      <= st_d.pos;
      busy_q     <= (st_d.mode != MODE_IDLE);
      stepped_q  <= flags.stepped;
      rejected_q <= flags.rejected;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coils_o     = coils_q;
  assign position_o  = pos_q;
  assign busy_res_o  = busy_q;
  assign stepped_o   = stepped_q;
  assign rejected_o  = rejected_q;

  `SMSS_ASSERT(a_busy_has_steps, (st_q.mode == MODE_IDLE) || (st_q.left != '0), "busy, no steps")
  `SMSS_ASSERT(a_home_tick_range, st_q.mode != MODE_HOME || st_q.tick < HOME_DELAY, "home tick")
  `SMSS_ASSERT(a_reject_busy, !(out_valid_q && rejected_q) || busy_q && !stepped_q, "bad reject")
  `SMSS_ASSERT_NEXT(a_accept_loads, in_acc, v1_q, "accepted request lost at input stage")

endmodule
